[rtl/assert_macros.svh]
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, masked while reset is asserted.
`define ASSERT_CLK(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Clocked assertion that also holds across reset.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/iptl_pkg.sv]
// Shared types, constants and code-set functions for the position table lookup.
package iptl_pkg;

    localparam int TABLE_DEPTH = 65536;
    localparam int POS_BITS    = 40;
    localparam int ADDR_BITS   = $clog2(TABLE_DEPTH);
    localparam int CNT_BITS    = $clog2(TABLE_DEPTH + 1);
    localparam int OUT_BITS    = POS_BITS + 1;
    localparam int CHAR_BITS   = 7;
    localparam int ENTRY_BITS  = POS_BITS + CHAR_BITS;

    // ASCII letters used by the code-set decode
    localparam logic [CHAR_BITS-1:0] ASC_LA = 7'h61;
    localparam logic [CHAR_BITS-1:0] ASC_LZ = 7'h7A;
    localparam logic [CHAR_BITS-1:0] ASC_A  = 7'h41;
    localparam logic [CHAR_BITS-1:0] ASC_B  = 7'h42;
    localparam logic [CHAR_BITS-1:0] ASC_C  = 7'h43;
    localparam logic [CHAR_BITS-1:0] ASC_D  = 7'h44;
    localparam logic [CHAR_BITS-1:0] ASC_G  = 7'h47;
    localparam logic [CHAR_BITS-1:0] ASC_H  = 7'h48;
    localparam logic [CHAR_BITS-1:0] ASC_K  = 7'h4B;
    localparam logic [CHAR_BITS-1:0] ASC_M  = 7'h4D;
    localparam logic [CHAR_BITS-1:0] ASC_R  = 7'h52;
    localparam logic [CHAR_BITS-1:0] ASC_S  = 7'h53;
    localparam logic [CHAR_BITS-1:0] ASC_T  = 7'h54;
    localparam logic [CHAR_BITS-1:0] ASC_V  = 7'h56;
    localparam logic [CHAR_BITS-1:0] ASC_W  = 7'h57;
    localparam logic [CHAR_BITS-1:0] ASC_Y  = 7'h59;

    localparam logic [CHAR_BITS-1:0] CASE_OFFSET = 7'd32;

    // base set bits
    localparam logic [3:0] BS_A = 4'b0001;
    localparam logic [3:0] BS_C = 4'b0010;
    localparam logic [3:0] BS_G = 4'b0100;
    localparam logic [3:0] BS_T = 4'b1000;

    typedef enum logic [1:0] {
        CMD_CLEAR = 2'd0,
        CMD_LOAD  = 2'd1,
        CMD_QUERY = 2'd2
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SRCH_RD,
        ST_SRCH_CMP,
        ST_PREV_RD,
        ST_NEXT_RD,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic take;
        logic search_rd;
        logic search_cmp;
        logic prev_rd;
        logic next_rd;
        logic out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic search_done;
    } dp_stat_t;

    function automatic logic [CHAR_BITS-1:0] upcase(input logic [CHAR_BITS-1:0] c);
        logic [CHAR_BITS-1:0] v;
        v = c;
        if (c inside {[ASC_LA:ASC_LZ]}) begin
            v = c - CASE_OFFSET;
        end
        return v;
    endfunction

    function automatic logic [3:0] base_bit(input logic [CHAR_BITS-1:0] b);
        logic [3:0] r;
        case (upcase(b))
            ASC_A:   r = BS_A;
            ASC_C:   r = BS_C;
            ASC_G:   r = BS_G;
            ASC_T:   r = BS_T;
            default: r = 4'b0000;
        endcase
        return r;
    endfunction

    function automatic logic [3:0] code_set(input logic [CHAR_BITS-1:0] c);
        logic [3:0] r;
        case (upcase(c))
            ASC_R:   r = BS_A | BS_G;
            ASC_Y:   r = BS_C | BS_T;
            ASC_S:   r = BS_C | BS_G;
            ASC_W:   r = BS_A | BS_T;
            ASC_K:   r = BS_T | BS_G;
            ASC_M:   r = BS_A | BS_C;
            ASC_B:   r = BS_C | BS_G | BS_T;
            ASC_D:   r = BS_A | BS_G | BS_T;
            ASC_H:   r = BS_A | BS_C | BS_T;
            ASC_V:   r = BS_A | BS_C | BS_G;
            default: r = 4'b0000;
        endcase
        return r;
    endfunction

endpackage

[rtl/iptl_ctrl.sv]
// Controller state machine: sequences accept, search steps, neighbor reads and result hand-off.
module iptl_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [1:0]           s_cmd,
    output logic                 m_valid,
    input  logic                 m_ready,
    output iptl_pkg::ctrl_cmd_t  ctrl_cmd,
    input  iptl_pkg::dp_stat_t   dp_stat
);
    import iptl_pkg::*;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        ctrl_cmd     = '0;
        s_ready      = 1'b0;
        // drop the held result once it is taken
        m_valid_next = m_valid_reg & ~m_ready;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    ctrl_cmd.take = 1'b1;
                    state_next = (s_cmd == CMD_QUERY) ? ST_SRCH_RD : ST_FINISH;
                end
            end
            ST_SRCH_RD: begin
                if (dp_stat.search_done) begin
                    state_next = ST_PREV_RD;
                end else begin
                    ctrl_cmd.search_rd = 1'b1;
                    state_next = ST_SRCH_CMP;
                end
            end
            ST_SRCH_CMP: begin
                ctrl_cmd.search_cmp = 1'b1;
                state_next = ST_SRCH_RD;
            end
            ST_PREV_RD: begin
                ctrl_cmd.prev_rd = 1'b1;
                state_next = ST_NEXT_RD;
            end
            ST_NEXT_RD: begin
                ctrl_cmd.next_rd = 1'b1;
                state_next = ST_FINISH;
            end
            ST_FINISH: begin
                // hold until the output register is free
                if (!m_valid_reg || m_ready) begin
                    ctrl_cmd.out_load = 1'b1;
                    m_valid_next = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_valid = m_valid_reg;

endmodule

[rtl/iptl_datapath.sv]
// Datapath: entry memory, load accumulator, binary search registers and result registers.
module iptl_datapath (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  iptl_pkg::ctrl_cmd_t                   ctrl_cmd,
    output iptl_pkg::dp_stat_t                    dp_stat,
    input  logic [1:0]                            s_cmd,
    input  logic [iptl_pkg::POS_BITS-1:0]         s_delta_pos,
    input  logic [iptl_pkg::CHAR_BITS-1:0]        s_entry_code,
    input  logic [iptl_pkg::POS_BITS-1:0]         s_position,
    input  logic [iptl_pkg::POS_BITS-1:0]         s_range_genome_start,
    input  logic [iptl_pkg::POS_BITS-1:0]         s_range_first_pos,
    input  logic [iptl_pkg::CHAR_BITS-1:0]        s_query_base,
    input  logic                                  s_reverse,
    output logic                                  m_status,
    output logic [iptl_pkg::CHAR_BITS-1:0]        m_found_code,
    output logic                                  m_included,
    output logic signed [iptl_pkg::OUT_BITS-1:0]  m_last_pos,
    output logic                                  m_next_valid,
    output logic signed [iptl_pkg::OUT_BITS-1:0]  m_next_pos
);
    import iptl_pkg::*;

    // table storage
    logic [ENTRY_BITS-1:0] mem [TABLE_DEPTH];
    logic [ENTRY_BITS-1:0] rd_reg;
    logic [ADDR_BITS-1:0]  rd_addr;
    logic                  rd_en;

    // table fill state
    logic [CNT_BITS-1:0]   count_reg;
    logic [POS_BITS-1:0]   running_reg;
    logic [POS_BITS-1:0]   run_sum;
    logic                  full_now;
    logic                  do_load;

    // captured request
    logic                  is_query_reg;
    logic                  full_reg;
    logic [POS_BITS-1:0]   gpos_reg;
    logic [OUT_BITS-1:0]   off_reg;
    logic [POS_BITS-1:0]   pos_reg;
    logic [CHAR_BITS-1:0]  qbase_reg;
    logic                  rev_reg;

    // search window [lo, hi)
    logic [CNT_BITS-1:0]   lo_reg;
    logic [CNT_BITS-1:0]   hi_reg;
    logic                  hit_reg;
    logic [CHAR_BITS-1:0]  char_reg;
    logic [CNT_BITS:0]     mid_sum;
    logic [CNT_BITS-1:0]   mid;
    logic [CNT_BITS-1:0]   mid_p1;
    logic [POS_BITS-1:0]   rd_pos;

    // neighbor reads
    logic [POS_BITS-1:0]   prev_e_reg;
    logic [CNT_BITS-1:0]   idx_m1;
    logic [CNT_BITS:0]     idx_fwd;

    // result
    logic [OUT_BITS-1:0]   contig_prev;
    logic [OUT_BITS-1:0]   contig_next;
    logic                  idx_nz;
    logic                  next_ok;
    logic                  incl_w;
    logic [OUT_BITS-1:0]   last_w;
    logic [OUT_BITS-1:0]   next_w;

    logic                  status_out_reg;
    logic [CHAR_BITS-1:0]  found_out_reg;
    logic                  incl_out_reg;
    logic [OUT_BITS-1:0]   last_out_reg;
    logic                  nvalid_out_reg;
    logic [OUT_BITS-1:0]   npos_out_reg;

    assign full_now = (count_reg == CNT_BITS'(TABLE_DEPTH));
    assign run_sum  = running_reg + s_delta_pos;
    assign do_load  = ctrl_cmd.take && (s_cmd == CMD_LOAD) && !full_now;

    assign mid_sum = {1'b0, lo_reg} + {1'b0, hi_reg} - (CNT_BITS+1)'(1);
    assign mid     = mid_sum[CNT_BITS:1];
    assign mid_p1  = mid + CNT_BITS'(1);
    assign rd_pos  = rd_reg[POS_BITS-1:0];

    assign idx_m1  = lo_reg - CNT_BITS'(1);
    assign idx_fwd = {1'b0, lo_reg} + (CNT_BITS+1)'(hit_reg);

    assign dp_stat.search_done = hit_reg || (lo_reg >= hi_reg);

    always_comb begin
        rd_en   = ctrl_cmd.search_rd | ctrl_cmd.prev_rd | ctrl_cmd.next_rd;
        rd_addr = mid[ADDR_BITS-1:0];
        if (ctrl_cmd.prev_rd) begin
            rd_addr = idx_m1[ADDR_BITS-1:0];
        end else if (ctrl_cmd.next_rd) begin
            rd_addr = rev_reg ? idx_m1[ADDR_BITS-1:0] : idx_fwd[ADDR_BITS-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (do_load) begin
            mem[count_reg[ADDR_BITS-1:0]] <= {s_entry_code, run_sum};
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            running_reg <= '0;
        end else if (ctrl_cmd.take) begin
            case (s_cmd)
                CMD_CLEAR: begin
                    count_reg   <= '0;
                    running_reg <= '0;
                end
                CMD_LOAD: begin
                    if (!full_now) begin
                        count_reg   <= count_reg + CNT_BITS'(1);
                        running_reg <= run_sum;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl_cmd.take) begin
            is_query_reg <= (s_cmd == CMD_QUERY);
            full_reg     <= (s_cmd == CMD_LOAD) && full_now;
            gpos_reg     <= s_range_genome_start + s_position - s_range_first_pos;
            off_reg      <= {1'b0, s_range_first_pos} - {1'b0, s_range_genome_start};
            pos_reg      <= s_position;
            qbase_reg    <= s_query_base;
            rev_reg      <= s_reverse;
            lo_reg       <= '0;
            hi_reg       <= count_reg;
            hit_reg      <= 1'b0;
        end else if (ctrl_cmd.search_cmp) begin
            if (rd_pos == gpos_reg) begin
                hit_reg  <= 1'b1;
                lo_reg   <= mid;
                char_reg <= rd_reg[ENTRY_BITS-1:POS_BITS];
            end else if (gpos_reg < rd_pos) begin
                hi_reg <= mid;
            end else begin
                lo_reg <= mid_p1;
            end
        end
        if (ctrl_cmd.next_rd) begin
            prev_e_reg <= rd_pos;
        end
    end

    assign contig_prev = {1'b0, prev_e_reg} + off_reg;
    assign contig_next = {1'b0, rd_pos} + off_reg;
    assign idx_nz      = (lo_reg != '0);
    assign next_ok     = rev_reg ? idx_nz : (idx_fwd < {1'b0, count_reg});
    assign incl_w      = hit_reg && ((code_set(char_reg) & base_bit(qbase_reg)) != 4'b0000);

    always_comb begin
        if (hit_reg) begin
            last_w = {1'b0, pos_reg};
        end else if (idx_nz) begin
            last_w = contig_prev;
        end else begin
            last_w = '0;
        end
        if (next_ok) begin
            next_w = rev_reg ? contig_prev : contig_next;
        end else begin
            next_w = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl_cmd.out_load) begin
            status_out_reg <= full_reg;
            found_out_reg  <= (is_query_reg && hit_reg) ? char_reg : '0;
            incl_out_reg   <= is_query_reg && incl_w;
            last_out_reg   <= is_query_reg ? last_w : '0;
            nvalid_out_reg <= is_query_reg && next_ok;
            npos_out_reg   <= is_query_reg ? next_w : '0;
        end
    end

    assign m_status     = status_out_reg;
    assign m_found_code = found_out_reg;
    assign m_included   = incl_out_reg;
    assign m_last_pos   = $signed(last_out_reg);
    assign m_next_valid = nvalid_out_reg;
    assign m_next_pos   = $signed(npos_out_reg);

endmodule

[rtl/iupac_position_table_lookup_core.sv]
// Top level of the ambiguity-code position table with binary-search lookup.
//  - Input channel s_*: one request per valid/ready handshake. s_cmd selects
//    clear (empty the table), load (add a delta-coded entry with its code)
//    or query (look up a contig position). Unused fields are ignored.
//  - Result channel m_*: exactly one result per request, in request order.
//    Clear and load return zeros except m_status, which flags a load that
//    was dropped because all table entries are in use.
//  - Sequence: m_valid rises once the result is loaded into the output
//    register. A clear or load goes from accept straight to hand-off; a
//    query first runs its search steps, at most ceil(log2(n+1)) for n stored
//    entries, on the single read port: each step is one registered read
//    and one compare, and the two neighbor entries are two more reads.
//  - Flow: one request at a time; s_ready returns high the cycle after the
//    result is loaded.
//  - Stall: while m_ready is low the result holds in the output register;
//    the next request is still accepted and processed, and its result waits
//    until the held one is taken.
//  - Reset (aresetn low, synchronous): empty the table and drop any pending
//    result. Memory contents are not cleared.
module iupac_position_table_lookup_core (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic [1:0]                            s_cmd,
    input  logic [iptl_pkg::POS_BITS-1:0]         s_delta_pos,
    input  logic [iptl_pkg::CHAR_BITS-1:0]        s_entry_code,
    input  logic [iptl_pkg::POS_BITS-1:0]         s_position,
    input  logic [iptl_pkg::POS_BITS-1:0]         s_range_genome_start,
    input  logic [iptl_pkg::POS_BITS-1:0]         s_range_first_pos,
    input  logic [iptl_pkg::CHAR_BITS-1:0]        s_query_base,
    input  logic                                  s_reverse,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic                                  m_status,
    output logic [iptl_pkg::CHAR_BITS-1:0]        m_found_code,
    output logic                                  m_included,
    output logic signed [iptl_pkg::OUT_BITS-1:0]  m_last_pos,
    output logic                                  m_next_valid,
    output logic signed [iptl_pkg::OUT_BITS-1:0]  m_next_pos
);
    import iptl_pkg::*;

    ctrl_cmd_t ctrl_cmd;
    dp_stat_t  dp_stat;

    // sequence each request: accept, search steps and neighbor reads for a query, hand-off
    iptl_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_cmd    (s_cmd),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .ctrl_cmd (ctrl_cmd),
        .dp_stat  (dp_stat)
    );

    // hold the table, run the compare/update and build the result
    iptl_datapath u_dp (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .ctrl_cmd             (ctrl_cmd),
        .dp_stat              (dp_stat),
        .s_cmd                (s_cmd),
        .s_delta_pos          (s_delta_pos),
        .s_entry_code         (s_entry_code),
        .s_position           (s_position),
        .s_range_genome_start (s_range_genome_start),
        .s_range_first_pos    (s_range_first_pos),
        .s_query_base         (s_query_base),
        .s_reverse            (s_reverse),
        .m_status             (m_status),
        .m_found_code         (m_found_code),
        .m_included           (m_included),
        .m_last_pos           (m_last_pos),
        .m_next_valid         (m_next_valid),
        .m_next_pos           (m_next_pos)
    );

endmodule

[rtl/iptl_checker.sv]
// Port-level checker for the position table lookup core, with its bind.
`include "assert_macros.svh"

module iptl_checker (
    input logic                                  aclk,
    input logic                                  aresetn,
    input logic                                  s_valid,
    input logic                                  s_ready,
    input logic                                  m_valid,
    input logic                                  m_ready,
    input logic                                  m_status,
    input logic [iptl_pkg::CHAR_BITS-1:0]        m_found_code,
    input logic                                  m_included,
    input logic                                  m_next_valid,
    input logic signed [iptl_pkg::OUT_BITS-1:0]  m_next_pos
);

    `ASSERT_ALWAYS(a_reset_clears_out, aclk, !aresetn |=> !m_valid, "result valid after reset")

    `ASSERT_CLK(a_out_hold, aclk, aresetn, m_valid && !m_ready |=> m_valid && $stable(m_found_code) && $stable(m_next_pos), "stalled result changed")

    `ASSERT_CLK(a_incl_needs_code, aclk, aresetn, m_valid && m_included |-> m_found_code != 0, "base included without a found code")

    `ASSERT_CLK(a_no_next_zero, aclk, aresetn, m_valid && !m_next_valid |-> m_next_pos == 0, "next position set without next entry")

    `ASSERT_CLK(a_full_is_load, aclk, aresetn, m_valid && m_status |-> m_found_code == 0 && !m_next_valid, "full status on a query result")

endmodule

bind iupac_position_table_lookup_core iptl_checker u_iptl_checker (.*);
